// File: src/tsni_pkg.sv
package tsni_pkg;

   localparam int ByteW = 8;
   localparam int LenW  = 17;
   localparam int SumW  = 18;
   localparam int MaxW  = 9;

   // parse phases
   localparam logic [4:0] PH_REC_TYPE  = 5'd0;
   localparam logic [4:0] PH_REC_MAJOR = 5'd1;
   localparam logic [4:0] PH_REC_MINOR = 5'd2;
   localparam logic [4:0] PH_FRAG_HI   = 5'd3;
   localparam logic [4:0] PH_FRAG_LO   = 5'd4;
   localparam logic [4:0] PH_HS_TYPE   = 5'd5;
   localparam logic [4:0] PH_SESS_LEN  = 5'd6;
   localparam logic [4:0] PH_CS_HI     = 5'd7;
   localparam logic [4:0] PH_CS_LO     = 5'd8;
   localparam logic [4:0] PH_COMP_LEN  = 5'd9;
   localparam logic [4:0] PH_EXTS_HI   = 5'd10;
   localparam logic [4:0] PH_EXTS_LO   = 5'd11;
   localparam logic [4:0] PH_ETYPE_HI  = 5'd12;
   localparam logic [4:0] PH_ETYPE_LO  = 5'd13;
   localparam logic [4:0] PH_ELEN_HI   = 5'd14;
   localparam logic [4:0] PH_ELEN_LO   = 5'd15;
   localparam logic [4:0] PH_LIST_HI   = 5'd16;
   localparam logic [4:0] PH_LIST_LO   = 5'd17;
   localparam logic [4:0] PH_NAME_TYPE = 5'd18;
   localparam logic [4:0] PH_HLEN_HI   = 5'd19;
   localparam logic [4:0] PH_HLEN_LO   = 5'd20;
   localparam logic [4:0] PH_HOST_DATA = 5'd21;

   // final status codes
   localparam logic [1:0] ST_NONE       = 2'd0;
   localparam logic [1:0] ST_FOUND      = 2'd1;
   localparam logic [1:0] ST_INCOMPLETE = 2'd2;
   localparam logic [1:0] ST_ERROR      = 2'd3;

   localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
   localparam logic [7:0]  REC_MAJOR       = 8'h03;
   localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
   localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
   localparam logic [7:0]  NAME_HOST       = 8'h00;
   // handshake length (3) + client version (2) + random (32)
   localparam logic [15:0] HELLO_SKIP      = 16'd37;
   localparam logic [LenW-1:0] POS_MAX     = 17'h1FFFF;
   localparam logic [MaxW-1:0] MAX_HOST_RESET = 9'd256 - 9'd0;

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic [LenW-1:0]  buffer_length;
      logic             end_of_buffer;
   } beat_type;

   typedef struct packed {
      logic             has;
      logic [ByteW-1:0] host_byte;
      logic             byte_valid;
      logic [1:0]       status;
      logic             done_res;
   } result_type;

endpackage

// File: src/tls_sni_extractor.sv
// tls_sni_extractor: streams the server-name hostname out of a TLS ClientHello record
//
// req channel: one record byte per beat, with the buffer's total length and an end
//   mark on the last byte. The parser restarts after every end mark.
// rsp channel: zero or one beat per input byte. A hostname byte comes with
//   byte_valid set; each buffer ends in exactly one beat with done_res set and
//   status found, incomplete or error (the last hostname byte may carry both).
// csr port: csr_wr_en writes max_hostname_length; write only while idle.
//
// a byte sits in the input register and its result, once the output register is free,
//   is registered into the output register, which drives rsp_valid.
// throughput: one byte per cycle while the output register is free; the parse step is a
//   single pass of logic between the input register and the output register.
// a stalled receiver holds the output register; the input register keeps
//   taking one more byte, then req_ready drops until rsp_ready returns.
// reset: parser back to the record header, max_hostname_length back to 256,
//   both registers emptied.
module tls_sni_extractor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tsni_pkg::ByteW-1:0]        req_data_byte,
   input  logic [tsni_pkg::LenW-1:0]         req_buffer_length,
   input  logic                              req_end_of_buffer,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tsni_pkg::ByteW-1:0]        rsp_host_byte,
   output logic                              rsp_byte_valid,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_done_res,
   input  logic                              csr_wr_en,
   input  logic [tsni_pkg::MaxW-1:0]         csr_wr_data
);

   logic                   in_valid_ff;
   tsni_pkg::beat_type     in_beat_ff;
   logic                   out_valid_ff;
   tsni_pkg::result_type   out_res_ff;
   tsni_pkg::result_type   result;
   logic                   out_free;
   logic                   fire;
   logic                   req_take;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff.data_byte     <= req_data_byte;
         in_beat_ff.buffer_length <= req_buffer_length;
         in_beat_ff.end_of_buffer <= req_end_of_buffer;
      end
   end

   tsni_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .beat        (in_beat_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= result.has;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.has) begin
         out_res_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_host_byte  = out_res_ff.host_byte;
   assign rsp_byte_valid = out_res_ff.byte_valid;
   assign rsp_status     = out_res_ff.status;
   assign rsp_done_res   = out_res_ff.done_res;

endmodule

// File: src/tsni_core.sv
module tsni_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  tsni_pkg::beat_type                  beat,
   input  logic                                csr_wr_en,
   input  logic [tsni_pkg::MaxW-1:0]           csr_wr_data,
   output tsni_pkg::result_type                result
);

   logic [4:0]                  phase_ff, phase_in;
   logic [tsni_pkg::LenW-1:0]   pos_ff, pos_in;
   logic [15:0]                 skip_ff, skip_in;
   logic [tsni_pkg::LenW-1:0]   ext_end_ff, ext_end_in;
   logic [7:0]                  hold_ff, hold_in;
   logic [15:0]                 ext_type_ff, ext_type_in;
   logic [15:0]                 host_ff, host_in;
   logic                        decided_ff, decided_in;
   logic [tsni_pkg::MaxW-1:0]   max_host_ff;

   logic [7:0]                  b;
   logic [15:0]                 w;
   logic [15:0]                 host_dec;
   logic [tsni_pkg::SumW-1:0]   p18, len18, end18;
   logic [tsni_pkg::SumW-1:0]   s_p1, s_hello, s_b3, s_cs, s_w1, s_sni, s_skip, s_frag;
   logic                        fin;
   logic [1:0]                  fin_st;
   logic                        host_out;

   assign b        = beat.data_byte;
   assign w        = {hold_ff, b};
   assign host_dec = host_ff - 16'd1;
   assign p18      = {1'b0, pos_ff};
   assign len18    = {1'b0, beat.buffer_length};
   assign end18    = {1'b0, ext_end_ff};

   assign s_p1    = p18 + 18'd1;
   assign s_hello = p18 + 18'd38;
   assign s_b3    = p18 + 18'd3 + {10'd0, b};
   assign s_cs    = p18 + 18'd2 + {2'd0, w};
   assign s_w1    = p18 + 18'd1 + {2'd0, w};
   assign s_sni   = p18 + 18'd3;
   assign s_skip  = p18 + 18'd5 + {2'd0, w};
   assign s_frag  = 18'd5 + {2'd0, w};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      skip_in     = skip_ff;
      ext_end_in  = ext_end_ff;
      hold_in     = hold_ff;
      ext_type_in = ext_type_ff;
      host_in     = host_ff;
      fin         = 1'b0;
      fin_st      = tsni_pkg::ST_NONE;
      host_out    = 1'b0;

      if (!decided_ff) begin
         if (skip_ff != 16'd0) begin
            skip_in = skip_ff - 16'd1;
         end else begin
            case (phase_ff)
               tsni_pkg::PH_REC_TYPE: begin
                  if (len18 < 18'd5) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_INCOMPLETE;
                  end else if (b != tsni_pkg::REC_HANDSHAKE) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     phase_in = tsni_pkg::PH_REC_MAJOR;
                  end
               end
               tsni_pkg::PH_REC_MAJOR: begin
                  if (b != tsni_pkg::REC_MAJOR) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     phase_in = tsni_pkg::PH_REC_MINOR;
                  end
               end
               tsni_pkg::PH_REC_MINOR: begin
                  phase_in = tsni_pkg::PH_FRAG_HI;
               end
               tsni_pkg::PH_FRAG_LO: begin
                  if (len18 < s_frag) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_INCOMPLETE;
                  end else begin
                     phase_in = tsni_pkg::PH_HS_TYPE;
                  end
               end
               tsni_pkg::PH_HS_TYPE: begin
                  if (b != tsni_pkg::HS_CLIENT_HELLO) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     skip_in = tsni_pkg::HELLO_SKIP;
                     if (s_hello >= len18) begin
                        fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                     end else begin
                        phase_in = tsni_pkg::PH_SESS_LEN;
                     end
                  end
               end
               tsni_pkg::PH_SESS_LEN: begin
                  if (s_b3 >= len18) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     skip_in  = {8'd0, b};
                     phase_in = tsni_pkg::PH_CS_HI;
                  end
               end
               tsni_pkg::PH_CS_LO: begin
                  if (s_cs >= len18) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     skip_in  = w;
                     phase_in = tsni_pkg::PH_COMP_LEN;
                  end
               end
               tsni_pkg::PH_COMP_LEN: begin
                  if (s_b3 >= len18) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     skip_in  = {8'd0, b};
                     phase_in = tsni_pkg::PH_EXTS_HI;
                  end
               end
               tsni_pkg::PH_EXTS_LO: begin
                  if (s_w1 > len18) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_INCOMPLETE;
                  end else begin
                     ext_end_in = s_w1[tsni_pkg::LenW-1:0];
                     // no room for even one extension header
                     if (w < 16'd4) begin
                        fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                     end else begin
                        phase_in = tsni_pkg::PH_ETYPE_HI;
                     end
                  end
               end
               tsni_pkg::PH_ETYPE_LO: begin
                  ext_type_in = w;
                  phase_in    = tsni_pkg::PH_ELEN_HI;
               end
               tsni_pkg::PH_ELEN_LO: begin
                  if (ext_type_ff == tsni_pkg::EXT_SERVER_NAME) begin
                     if (s_sni > end18) begin
                        fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                     end else begin
                        phase_in = tsni_pkg::PH_LIST_HI;
                     end
                  end else begin
                     // skip this extension, next header must still fit
                     if (s_skip > end18) begin
                        fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                     end else begin
                        skip_in  = w;
                        phase_in = tsni_pkg::PH_ETYPE_HI;
                     end
                  end
               end
               tsni_pkg::PH_LIST_HI: begin
                  phase_in = tsni_pkg::PH_LIST_LO;
               end
               tsni_pkg::PH_LIST_LO: begin
                  phase_in = tsni_pkg::PH_NAME_TYPE;
               end
               tsni_pkg::PH_NAME_TYPE: begin
                  if (b != tsni_pkg::NAME_HOST) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else begin
                     phase_in = tsni_pkg::PH_HLEN_HI;
                  end
               end
               tsni_pkg::PH_HLEN_LO: begin
                  if ((s_w1 > end18) || (w >= {7'd0, max_host_ff})) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
                  end else if (w == 16'd0) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_FOUND;
                  end else begin
                     host_in  = w;
                     phase_in = tsni_pkg::PH_HOST_DATA;
                  end
               end
               tsni_pkg::PH_HOST_DATA: begin
                  host_out = 1'b1;
                  host_in  = host_dec;
                  if (host_dec == 16'd0) begin
                     fin = 1'b1; fin_st = tsni_pkg::ST_FOUND;
                  end
               end
               tsni_pkg::PH_FRAG_HI, tsni_pkg::PH_CS_HI, tsni_pkg::PH_EXTS_HI,
               tsni_pkg::PH_ETYPE_HI, tsni_pkg::PH_ELEN_HI, tsni_pkg::PH_HLEN_HI: begin
                  hold_in  = b;
                  phase_in = phase_ff + 5'd1;
               end
               default: begin
                  fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
               end
            endcase
         end
         // the next byte would lie past the buffer end
         if (!fin && (s_p1 >= len18)) begin
            fin = 1'b1; fin_st = tsni_pkg::ST_ERROR;
         end
      end

      if (pos_ff != tsni_pkg::POS_MAX) begin
         pos_in = pos_ff + 17'd1;
      end

      if (beat.end_of_buffer && !decided_ff && !fin) begin
         fin = 1'b1; fin_st = tsni_pkg::ST_INCOMPLETE;
      end

      decided_in = decided_ff | fin;

      if (beat.end_of_buffer) begin
         phase_in    = tsni_pkg::PH_REC_TYPE;
         pos_in      = '0;
         skip_in     = '0;
         ext_end_in  = '0;
         hold_in     = '0;
         ext_type_in = '0;
         host_in     = '0;
         decided_in  = 1'b0;
      end

      result.has        = fin | host_out;
      result.host_byte  = host_out ? b : 8'd0;
      result.byte_valid = host_out;
      result.status     = fin_st;
      result.done_res   = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= tsni_pkg::PH_REC_TYPE;
         pos_ff      <= '0;
         skip_ff     <= '0;
         ext_end_ff  <= '0;
         hold_ff     <= '0;
         ext_type_ff <= '0;
         host_ff     <= '0;
         decided_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         ext_end_ff  <= ext_end_in;
         hold_ff     <= hold_in;
         ext_type_ff <= ext_type_in;
         host_ff     <= host_in;
         decided_ff  <= decided_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_host_ff <= tsni_pkg::MAX_HOST_RESET;
      end else if (csr_wr_en) begin
         max_host_ff <= csr_wr_data;
      end
   end

   // once decided, nothing more is produced until the end mark
   a_quiet_after_done: assert property (@(posedge clock) disable iff (reset)
      fire && decided_ff |-> !result.has)
      else $error("result produced after final status");

   a_sticky_decided: assert property (@(posedge clock) disable iff (reset)
      fire && decided_ff && !beat.end_of_buffer |=> decided_ff)
      else $error("decided cleared without end mark");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      fire && beat.end_of_buffer |=> !decided_ff && (pos_ff == '0)
         && (phase_ff == tsni_pkg::PH_REC_TYPE))
      else $error("parser did not restart after end mark");

   a_host_phase: assert property (@(posedge clock) disable iff (reset)
      fire && result.byte_valid |-> (phase_ff == tsni_pkg::PH_HOST_DATA) && (host_ff != 16'd0))
      else $error("hostname byte outside hostname field");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      fire && result.done_res |-> (result.status != tsni_pkg::ST_NONE))
      else $error("final result without status");

endmodule
